/* rtl/jsd_pkg.sv */
// ----------------------------------------------------------------------------
// jsd_pkg
// Shared types, widths and controller codes for the job sequencing block.
// ----------------------------------------------------------------------------
package jsd_pkg;

   localparam int MAX_JOBS   = 64;
   localparam int JOB_ADDR_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int JOB_CNT_W  = $clog2(MAX_JOBS + 1);

   localparam int DEADLINE_W = 16;
   localparam int PROFIT_W   = 16;
   localparam int DONE_W     = 7;
   localparam int SUM_W      = 22;

   typedef struct packed {
      logic [DEADLINE_W-1:0] deadline;
      logic [PROFIT_W-1:0]   profit;
      logic                  last_job;
   } jsd_req_type;

   typedef struct packed {
      logic [DONE_W-1:0] jobs_done;
      logic [SUM_W-1:0]  total_profit;
   } jsd_rsp_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_SCAN,
      ST_SCAN_END,
      ST_FETCH,
      ST_TAKE,
      ST_SEARCH,
      ST_NEXT,
      ST_DONE
   } jsd_state_type;

   typedef struct packed {
      logic store;
      logic clear;
      logic scan;
      logic fetch;
      logic take_dl;
      logic place;
      logic step_down;
      logic pass_next;
      logic publish;
   } jsd_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic pass_last;
      logic best_found;
      logic ptr_zero;
      logic slot_free;
      logic out_busy;
   } jsd_status_type;

endpackage

/* rtl/jsd_ram.sv */
// ----------------------------------------------------------------------------
// jsd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* rtl/jsd_ctrl.sv */
// ----------------------------------------------------------------------------
// jsd_ctrl
// Sequencer: load jobs, then per job run one max-profit scan and a slot search.
// ----------------------------------------------------------------------------
module jsd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   input  jsd_pkg::jsd_status_type status,
   output logic                    req_ready,
   output jsd_pkg::jsd_cmd_type    cmd,
   output jsd_pkg::jsd_state_type  state
);
   import jsd_pkg::*;

   jsd_state_type state_ff;
   jsd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.store = 1'b1;
               if (req_last) begin
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            cmd.clear = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_TAKE;
         end
         ST_TAKE: begin
            cmd.take_dl = 1'b1;
            state_in    = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (status.ptr_zero) begin
               state_in = ST_NEXT;
            end else if (status.slot_free) begin
               cmd.place = 1'b1;
               state_in  = ST_NEXT;
            end else begin
               cmd.step_down = 1'b1;
            end
         end
         ST_NEXT: begin
            if (status.pass_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.pass_next = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.publish = 1'b1;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign state = state_ff;

endmodule

/* rtl/jsd_dpath.sv */
// ----------------------------------------------------------------------------
// jsd_dpath
// Job store, max-profit scan, slot map, accumulators and response register.
// ----------------------------------------------------------------------------
module jsd_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  jsd_pkg::jsd_req_type    req_data,
   input  jsd_pkg::jsd_cmd_type    cmd,
   input  logic                    rsp_ready,
   output jsd_pkg::jsd_status_type status,
   output logic                    rsp_valid,
   output jsd_pkg::jsd_rsp_type    rsp_data
);
   import jsd_pkg::*;

   logic [JOB_CNT_W-1:0]  job_total_ff,  job_total_in;
   logic [JOB_ADDR_W-1:0] scan_addr_ff,  scan_addr_in;
   logic [JOB_ADDR_W-1:0] rd_idx_ff;
   logic                  rd_pend_ff;
   logic [PROFIT_W-1:0]   best_prof_ff,  best_prof_in;
   logic [JOB_ADDR_W-1:0] best_idx_ff,   best_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [JOB_CNT_W-1:0]  pass_ff,       pass_in;
   logic [JOB_CNT_W-1:0]  ptr_ff,        ptr_in;
   logic [MAX_JOBS-1:0]   done_ff,       done_in;
   logic [MAX_JOBS-1:0]   slot_ff,       slot_in;
   logic [JOB_CNT_W-1:0]  placed_ff,     placed_in;
   logic [SUM_W-1:0]      sum_ff,        sum_in;
   logic                  rsp_valid_ff,  rsp_valid_in;
   jsd_rsp_type           rsp_data_ff,   rsp_data_in;

   logic                  wr_en;
   logic [JOB_CNT_W-1:0]  dl_clamped;
   logic [JOB_ADDR_W-1:0] rd_addr;
   logic [PROFIT_W-1:0]   prof_rd;
   logic [JOB_CNT_W-1:0]  dl_rd;
   logic [JOB_ADDR_W-1:0] slot_idx;
   logic                  better;

   // clamp deadlines to the number of slots
   assign dl_clamped = (req_data.deadline > DEADLINE_W'(MAX_JOBS)) ?
                       JOB_CNT_W'(MAX_JOBS) : req_data.deadline[JOB_CNT_W-1:0];
   assign wr_en      = cmd.store && (job_total_ff < JOB_CNT_W'(MAX_JOBS));
   assign rd_addr    = cmd.fetch ? best_idx_ff : scan_addr_ff;
   assign slot_idx   = JOB_ADDR_W'(ptr_ff - 1'b1);

   jsd_ram #(.WIDTH(PROFIT_W), .DEPTH(MAX_JOBS)) u_profit_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (job_total_ff[JOB_ADDR_W-1:0]),
      .wr_data (req_data.profit),
      .rd_addr (rd_addr),
      .rd_data (prof_rd)
   );

   jsd_ram #(.WIDTH(JOB_CNT_W), .DEPTH(MAX_JOBS)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (job_total_ff[JOB_ADDR_W-1:0]),
      .wr_data (dl_clamped),
      .rd_addr (rd_addr),
      .rd_data (dl_rd)
   );

   // strict greater keeps the earliest job among equal profits
   assign better = rd_pend_ff && !done_ff[rd_idx_ff] &&
                   (!best_found_ff || (prof_rd > best_prof_ff));

   always_comb begin
      job_total_in  = job_total_ff;
      scan_addr_in  = scan_addr_ff;
      best_prof_in  = best_prof_ff;
      best_idx_in   = best_idx_ff;
      best_found_in = best_found_ff;
      pass_in       = pass_ff;
      ptr_in        = ptr_ff;
      done_in       = done_ff;
      slot_in       = slot_ff;
      placed_in     = placed_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;

      if (wr_en) begin
         job_total_in = job_total_ff + 1'b1;
      end
      if (better) begin
         best_prof_in  = prof_rd;
         best_idx_in   = rd_idx_ff;
         best_found_in = 1'b1;
      end
      if (cmd.scan) begin
         scan_addr_in = scan_addr_ff + 1'b1;
      end
      if (cmd.clear) begin
         done_in       = '0;
         slot_in       = '0;
         placed_in     = '0;
         sum_in        = '0;
         pass_in       = '0;
         scan_addr_in  = '0;
         best_found_in = 1'b0;
      end
      if (cmd.pass_next) begin
         pass_in       = pass_ff + 1'b1;
         scan_addr_in  = '0;
         best_found_in = 1'b0;
      end
      if (cmd.fetch) begin
         done_in[best_idx_ff] = 1'b1;
      end
      if (cmd.take_dl) begin
         ptr_in = dl_rd;
      end
      if (cmd.step_down) begin
         ptr_in = ptr_ff - 1'b1;
      end
      if (cmd.place) begin
         slot_in[slot_idx] = 1'b1;
         placed_in         = placed_ff + 1'b1;
         sum_in            = sum_ff + SUM_W'(best_prof_ff);
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.jobs_done    = DONE_W'(placed_ff);
         rsp_data_in.total_profit = sum_ff;
         job_total_in             = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_total_ff <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_total_ff <= job_total_in;
         rd_pend_ff   <= cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff  <= scan_addr_in;
      rd_idx_ff     <= scan_addr_ff;
      best_prof_ff  <= best_prof_in;
      best_idx_ff   <= best_idx_in;
      best_found_ff <= best_found_in;
      pass_ff       <= pass_in;
      ptr_ff        <= ptr_in;
      done_ff       <= done_in;
      slot_ff       <= slot_in;
      placed_ff     <= placed_in;
      sum_ff        <= sum_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign status.scan_last  = (scan_addr_ff == JOB_ADDR_W'(job_total_ff - 1'b1));
   assign status.pass_last  = (JOB_CNT_W'(pass_ff + 1'b1) == job_total_ff);
   assign status.best_found = best_found_ff;
   assign status.ptr_zero   = (ptr_ff == '0);
   assign status.slot_free  = !slot_ff[slot_idx];
   assign status.out_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* rtl/job_sequencing_with_deadlines_core.sv */
// ----------------------------------------------------------------------------
// job_sequencing_with_deadlines_core
// Greedy job sequencing: load a batch of unit-time jobs, report the count and
// total profit of the jobs that fit in slots before their deadlines.
// ----------------------------------------------------------------------------
// Jobs arrive one request per cycle on req_; the request with last_job set
// closes the batch and req_ready drops until the batch result has been moved
// into the rsp_ output register. Up to MAX_JOBS (64) jobs are stored; further
// jobs in the same batch are dropped, though a dropped last_job still ends the
// batch. For each stored job, one full scan of the single-read-port job RAM
// finds the highest remaining profit, then the slot search walks down from the
// job's deadline one slot per cycle, stepping over occupied slots (at most
// MAX_JOBS per job). Ties in profit go to the earlier job. Deadlines of zero
// never place; deadlines above MAX_JOBS are clamped. A finished result waits
// in the output register while the next batch loads; a batch that finishes
// while the previous result still waits holds until that result is taken.
// ----------------------------------------------------------------------------
module job_sequencing_with_deadlines_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  jsd_pkg::jsd_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output jsd_pkg::jsd_rsp_type rsp_data
);
   import jsd_pkg::*;

   jsd_cmd_type    cmd;
   jsd_status_type status;
   jsd_state_type  state;

   // sequence the load, scan and search phases
   jsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.last_job),
      .status    (status),
      .req_ready (req_ready),
      .cmd       (cmd),
      .state     (state)
   );

   // hold jobs, slot map, running totals and the response register
   jsd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a new response only ever comes from the publish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state) == ST_DONE)
      else $error("response raised outside publish step");

   // every pass must find an unprocessed job before fetching its deadline
   assert property (@(posedge clock) disable iff (reset)
      state == ST_FETCH |-> status.best_found)
      else $error("scan ended without a candidate job");

   // a closing request starts the batch computation on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.last_job) |=> state == ST_INIT)
      else $error("batch did not start after last job");

endmodule
